// ===== design/apsk_nearest_point_demapper_top_macros.svh =====
// Assertion macros shared by the demapper RTL.
`ifndef APSK_NEAREST_POINT_DEMAPPER_TOP_MACROS_SVH
`define APSK_NEAREST_POINT_DEMAPPER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define APSK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define APSK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/apsk_pkg.sv =====
// Package with the shared types and constants of the APSK demapper.
package apsk_pkg;

  localparam int unsigned INDEX_W = 8;
  localparam int unsigned LABEL_W = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_DEMOD = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  // Control tag that travels with each table read down the pipeline.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tag_t;

endpackage

// ===== design/apsk_if.sv =====
// Valid/ready channel interfaces for demapper input and result words.
interface apsk_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [apsk_pkg::INDEX_W-1:0]        entry_index;
  logic signed [COORD_WIDTH-1:0]       entry_i;
  logic signed [COORD_WIDTH-1:0]       entry_q;
  logic [apsk_pkg::LABEL_W-1:0]        entry_label;
  logic signed [COORD_WIDTH-1:0]       sample_i;
  logic signed [COORD_WIDTH-1:0]       sample_q;

  modport source (
    output valid, func, entry_index, entry_i, entry_q, entry_label, sample_i, sample_q,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_i, entry_q, entry_label, sample_i, sample_q,
    output ready
  );
endinterface

interface apsk_out_if;
  logic                         valid;
  logic                         ready;
  logic [apsk_pkg::LABEL_W-1:0] symbol_label;

  modport source (
    output valid, symbol_label,
    input  ready
  );
  modport sink (
    input  valid, symbol_label,
    output ready
  );
endinterface

// ===== design/apsk_nearest_point_demapper_top.sv =====
// A demodulate word returns its label once all N scanned points are compared; a load word gives no result.
// The block takes no new word until the previous label has been loaded into the output register.
// The scan is set by the single table read port: one point is fetched and compared per cycle.
// Reset (asynchronous, active low) clears control state and sets the point count to one.
// The point tables are not cleared; entries read before they are loaded are undefined.
`include "apsk_nearest_point_demapper_top_macros.svh"

module apsk_nearest_point_demapper_top #(
  parameter int unsigned MAX_POINTS  = 256,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [apsk_pkg::COUNT_W-1:0]    cfg_wdata_i,
  apsk_in_if.sink                         in_i,
  apsk_out_if.source                      out_o
);

  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CNTW   = $clog2(MAX_POINTS + 1);
  localparam int unsigned CMPW   = (CNTW > apsk_pkg::COUNT_W) ? CNTW : apsk_pkg::COUNT_W;
  localparam int unsigned IDXCW  = (CNTW > apsk_pkg::INDEX_W) ? CNTW : apsk_pkg::INDEX_W;
  localparam int unsigned DW     = COORD_WIDTH + 1;
  localparam int unsigned PW     = 2 * DW;
  localparam int unsigned SW     = PW + 1;
  localparam int unsigned MEMW   = 2 * COORD_WIDTH + apsk_pkg::LABEL_W;

  apsk_pkg::state_e state_q, state_d;

  logic [apsk_pkg::COUNT_W-1:0] point_count_q;

  logic                          in_ready;
  logic                          in_fire;
  logic                          demod_start;
  logic                          issue;
  logic                          result_load;

  logic [AW-1:0]                 scan_idx_q;
  logic [AW-1:0]                 last_idx_q;
  logic [AW-1:0]                 last_idx_d;
  logic [CMPW-1:0]               count_ext;
  logic [CMPW-1:0]               n_eff;

  logic signed [COORD_WIDTH-1:0] si_q;
  logic signed [COORD_WIDTH-1:0] sq_q;

  logic [MEMW-1:0]               mem [MAX_POINTS];
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [MEMW-1:0]               mem_wdata;
  logic [MEMW-1:0]               rd_q;

  apsk_pkg::tag_t                p0, p1_q, p2_q, p3_q;

  logic signed [COORD_WIDTH-1:0] pt_i;
  logic signed [COORD_WIDTH-1:0] pt_q;
  logic [apsk_pkg::LABEL_W-1:0]  pt_label;

  logic signed [DW-1:0]          dr_q, di_q;
  logic [apsk_pkg::LABEL_W-1:0]  lab2_q, lab3_q;
  logic signed [PW-1:0]          prod_i, prod_q;
  logic [PW-1:0]                 sqi_q, sqq_q;
  logic [SW-1:0]                 d2;
  logic                          take;

  logic [SW-1:0]                 best_d2_q;
  logic [apsk_pkg::LABEL_W-1:0]  best_label_q;

  logic                          out_valid_q;
  logic [apsk_pkg::LABEL_W-1:0]  out_label_q;

  // ---------------------------------------------------------------------------
  // Handshake and control decode
  // ---------------------------------------------------------------------------
  assign in_fire     = in_i.valid && in_ready;
  assign demod_start = in_fire && (in_i.func == apsk_pkg::FUNC_DEMOD);

  // A zero count scans entry 0 only; a count above the table depth saturates.
  assign count_ext  = CMPW'(point_count_q);
  always_comb begin
    if (count_ext == '0) begin
      n_eff = CMPW'(1);
    end else if (count_ext > CMPW'(MAX_POINTS)) begin
      n_eff = CMPW'(MAX_POINTS);
    end else begin
      n_eff = count_ext;
    end
  end
  assign last_idx_d = AW'(n_eff - CMPW'(1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      apsk_pkg::ST_IDLE: begin
        if (demod_start) state_d = apsk_pkg::ST_SCAN;
      end
      apsk_pkg::ST_SCAN: begin
        if (scan_idx_q == last_idx_q) state_d = apsk_pkg::ST_DRAIN;
      end
      apsk_pkg::ST_DRAIN: begin
        if (p3_q.valid && p3_q.last) state_d = apsk_pkg::ST_RESULT;
      end
      apsk_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) state_d = apsk_pkg::ST_IDLE;
      end
      default: state_d = apsk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    issue       = 1'b0;
    result_load = 1'b0;
    case (state_q)
      apsk_pkg::ST_IDLE:   in_ready    = 1'b1;
      apsk_pkg::ST_SCAN:   issue       = 1'b1;
      apsk_pkg::ST_DRAIN:  issue       = 1'b0;
      apsk_pkg::ST_RESULT: result_load = !out_valid_q || out_o.ready;
      default:             in_ready    = 1'b0;
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= apsk_pkg::ST_IDLE;
      point_count_q <= apsk_pkg::COUNT_W'(1);
      scan_idx_q    <= '0;
      last_idx_q    <= '0;
      p1_q          <= '0;
      p2_q          <= '0;
      p3_q          <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        point_count_q <= cfg_wdata_i;
      end
      if (demod_start) begin
        scan_idx_q <= '0;
        last_idx_q <= last_idx_d;
      end else if (issue) begin
        scan_idx_q <= scan_idx_q + AW'(1);
      end
      p1_q <= p0;
      p2_q <= p1_q;
      p3_q <= p2_q;
      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Point table: written by load words, read once per cycle by the scan
  // ---------------------------------------------------------------------------
  assign mem_we    = in_fire && (in_i.func == apsk_pkg::FUNC_LOAD) &&
                     (IDXCW'(in_i.entry_index) < IDXCW'(MAX_POINTS));
  assign mem_waddr = AW'(in_i.entry_index);
  assign mem_wdata = {in_i.entry_i, in_i.entry_q, in_i.entry_label};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[scan_idx_q];
  end

  assign p0.valid = issue;
  assign p0.first = (scan_idx_q == '0);
  assign p0.last  = (scan_idx_q == last_idx_q);

  assign pt_i     = rd_q[MEMW-1 -: COORD_WIDTH];
  assign pt_q     = rd_q[apsk_pkg::LABEL_W +: COORD_WIDTH];
  assign pt_label = rd_q[apsk_pkg::LABEL_W-1:0];

  // ---------------------------------------------------------------------------
  // Distance datapath: difference, square, then sum and compare
  // ---------------------------------------------------------------------------
  assign prod_i = PW'(dr_q) * PW'(dr_q);
  assign prod_q = PW'(di_q) * PW'(di_q);
  assign d2     = SW'(sqi_q) + SW'(sqq_q);
  // Strict less-than keeps the lowest index on a tie.
  assign take   = p3_q.valid && (p3_q.first || (d2 < best_d2_q));

  always_ff @(posedge clk_i) begin
    if (demod_start) begin
      si_q <= in_i.sample_i;
      sq_q <= in_i.sample_q;
    end
    dr_q   <= DW'(si_q) - DW'(pt_i);
    di_q   <= DW'(sq_q) - DW'(pt_q);
    lab2_q <= pt_label;
    sqi_q  <= prod_i;
    sqq_q  <= prod_q;
    lab3_q <= lab2_q;
    if (take) begin
      best_d2_q    <= d2;
      best_label_q <= lab3_q;
    end
    if (result_load) begin
      out_label_q <= best_label_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.symbol_label = out_label_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `APSK_ASSERT_NOW(a_idle_pipe_empty, state_q == apsk_pkg::ST_IDLE,
                   !p1_q.valid && !p2_q.valid && !p3_q.valid,
                   "scan pipeline busy while idle")
  `APSK_ASSERT_NOW(a_one_last, 1'b1,
                   $countones({p1_q.valid && p1_q.last, p2_q.valid && p2_q.last,
                               p3_q.valid && p3_q.last}) <= 1,
                   "more than one final point in flight")
  `APSK_ASSERT_NEXT(a_start_scan, demod_start,
                    state_q == apsk_pkg::ST_SCAN && scan_idx_q == '0,
                    "demodulate word did not start a scan at entry zero")
  `APSK_ASSERT_NEXT(a_last_to_result, p3_q.valid && p3_q.last,
                    state_q == apsk_pkg::ST_RESULT,
                    "final compare did not lead to the result state")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the APSK nearest-point demapper top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPTS      = 256;
  localparam int unsigned DRAIN_GAP = 300;
  localparam int unsigned STALL_MAX = 4000;
  localparam int unsigned HOLD_LEN  = 600;
  localparam int unsigned RAND_WORDS = 400;

  typedef struct packed {
    logic                         func;
    logic [apsk_pkg::INDEX_W-1:0] idx;
    logic signed [15:0]           ei;
    logic signed [15:0]           eq;
    logic [apsk_pkg::LABEL_W-1:0] lbl;
    logic signed [15:0]           si;
    logic signed [15:0]           sq;
  } word_t;

  logic                         clk_i = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [apsk_pkg::COUNT_W-1:0] cfg_wdata = '0;
  logic                         drv_valid = 1'b0;
  word_t                        drv_word = '0;
  logic                         res_ready = 1'b0;

  apsk_in_if #(.COORD_WIDTH(16)) in_if ();
  apsk_out_if out_if ();

  assign in_if.valid       = drv_valid;
  assign in_if.func        = drv_word.func;
  assign in_if.entry_index = drv_word.idx;
  assign in_if.entry_i     = drv_word.ei;
  assign in_if.entry_q     = drv_word.eq;
  assign in_if.entry_label = drv_word.lbl;
  assign in_if.sample_i    = drv_word.si;
  assign in_if.sample_q    = drv_word.sq;
  assign out_if.ready      = res_ready;

  apsk_nearest_point_demapper_top #(
    .MAX_POINTS (NPTS),
    .COORD_WIDTH(16)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Words waiting for the driver and labels waiting for the output.
  word_t                        pending_words[$];
  logic [apsk_pkg::LABEL_W-1:0] pending_labels[$];

  // Predictor copy of the constellation and the point count.
  logic signed [15:0]           pt_i[NPTS];
  logic signed [15:0]           pt_q[NPTS];
  logic [apsk_pkg::LABEL_W-1:0] pt_lbl[NPTS];
  logic [apsk_pkg::COUNT_W-1:0] scan_count = apsk_pkg::COUNT_W'(1);

  // Stimulus-side copy, used to aim samples near loaded points.
  logic signed [15:0] g_i[NPTS];
  logic signed [15:0] g_q[NPTS];
  bit                 g_loaded[NPTS];

  bit          in_acc = 1'b0;
  bit          out_acc = 1'b0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned cyc = 0;
  int unsigned stall_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          quiet;

  assign quiet = (cyc >= 4000) && (cyc < 12000);

  function automatic logic [apsk_pkg::LABEL_W-1:0] nearest_label(logic signed [15:0] si,
                                                                 logic signed [15:0] sq);
    int unsigned n;
    int unsigned best;
    longint      best_d;
    longint      d;
    longint      di;
    longint      dq;
    n = 32'(scan_count);
    if (n == 0) n = 1;
    if (n > NPTS) n = NPTS;
    best   = 0;
    best_d = 0;
    for (int unsigned k = 0; k < n; k++) begin
      di = longint'(si) - longint'(pt_i[k]);
      dq = longint'(sq) - longint'(pt_q[k]);
      d  = di * di + dq * dq;
      // Strict compare keeps the lowest index on equal distances.
      if (k == 0 || d < best_d) begin
        best_d = d;
        best   = k;
      end
    end
    return pt_lbl[best];
  endfunction

  // Input driver: a word stays on the bus until it is taken.
  always @(negedge clk_i) begin
    if (rst_n) begin
      if (!drv_valid || in_acc) begin
        if (pending_words.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
          drv_word  <= pending_words.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver, with one long hold-off so the block backs up.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 30) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      res_ready <= 1'b0;
    end else begin
      res_ready <= quiet || $urandom_range(99) >= 25;
    end
  end

  // Monitor, predictor, checker and watchdog.
  always @(posedge clk_i) begin
    logic [apsk_pkg::LABEL_W-1:0] want;
    in_acc  = rst_n && in_if.valid && in_if.ready;
    out_acc = rst_n && out_if.valid && out_if.ready;
    cyc++;
    if (rst_n && cfg_we) scan_count = cfg_wdata;
    if (in_acc) begin
      if (in_if.func == apsk_pkg::FUNC_LOAD) begin
        pt_i[in_if.entry_index]   = in_if.entry_i;
        pt_q[in_if.entry_index]   = in_if.entry_q;
        pt_lbl[in_if.entry_index] = in_if.entry_label;
      end else begin
        want = nearest_label(in_if.sample_i, in_if.sample_q);
        pending_labels.insert(pending_labels.size(), want);
      end
    end
    if (out_acc) begin
      results_seen++;
      if (pending_labels.size() == 0) begin
        $error("unexpected result word, symbol_label %0d", out_if.symbol_label);
        errors++;
      end else begin
        want = pending_labels.pop_front();
        if (out_if.symbol_label !== want) begin
          $error("symbol_label mismatch: expected %0d, actual %0d", want,
                 out_if.symbol_label);
          errors++;
        end
      end
    end
    if (in_acc || out_acc || (rst_n && cfg_we)) stall_cyc = 0;
    else stall_cyc++;
    if (stall_cyc >= STALL_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_load(int unsigned idx, logic signed [15:0] ei,
                            logic signed [15:0] eq, logic [apsk_pkg::LABEL_W-1:0] lbl);
    word_t w;
    w.func = apsk_pkg::FUNC_LOAD;
    w.idx  = idx[apsk_pkg::INDEX_W-1:0];
    w.ei   = ei;
    w.eq   = eq;
    w.lbl  = lbl;
    w.si   = 16'($urandom);
    w.sq   = 16'($urandom);
    g_i[idx]      = ei;
    g_q[idx]      = eq;
    g_loaded[idx] = 1'b1;
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic queue_demod(logic signed [15:0] si, logic signed [15:0] sq);
    word_t w;
    w.func = apsk_pkg::FUNC_DEMOD;
    w.idx  = 8'($urandom);
    w.ei   = 16'($urandom);
    w.eq   = 16'($urandom);
    w.lbl  = 8'($urandom);
    w.si   = si;
    w.sq   = sq;
    pending_words.insert(pending_words.size(), w);
  endtask

  // Returns once every word is taken, every label is back and the scan has ended.
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_words.size() != 0 || drv_valid || pending_labels.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic write_count(logic [apsk_pkg::COUNT_W-1:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    #1;
  endtask

  function automatic logic signed [15:0] pick_coord();
    int c;
    case ($urandom_range(2))
      0:       c = int'($urandom_range(0, 65535)) - 32768;
      1:       c = int'($urandom_range(0, 31)) - 16;
      default: c = (int'($urandom_range(0, 15)) - 8) * 2048;
    endcase
    return c[15:0];
  endfunction

  initial begin
    int unsigned        n_words;
    int unsigned        phase;
    int unsigned        n_cfg;
    int unsigned        span;
    int unsigned        burst;
    int unsigned        k;
    int                 t;
    logic signed [15:0] si;
    logic signed [15:0] sq;

    repeat (12) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed: corner coordinates, a single-point scan, ties and count corners.
    queue_load(0, 16'sh7fff, 16'sh8000, 8'hff);
    queue_demod(16'sh8000, 16'sh7fff);
    queue_demod(16'sh7fff, 16'sh8000);
    write_count(apsk_pkg::COUNT_W'(4));
    queue_load(1, 16'sh8000, 16'sh7fff, 8'h00);
    queue_load(2, 16'sh0000, 16'sh0000, 8'ha5);
    queue_load(3, 16'sh0000, 16'sh0000, 8'h5a);
    queue_demod(16'sh0000, 16'sh0000);
    queue_demod(16'sh8000, 16'sh7fff);
    queue_demod(16'sh7fff, 16'sh8000);
    queue_demod(16'sh0001, 16'sh0001);
    write_count(apsk_pkg::COUNT_W'(6));
    queue_load(4, 16'sh1000, 16'sh0000, 8'h11);
    queue_load(5, -16'sh1000, 16'sh0000, 8'h22);
    queue_demod(16'sh0000, 16'sh1000);
    queue_demod(16'sh0800, 16'sh0000);
    queue_demod(-16'sh0800, 16'sh0000);
    write_count(apsk_pkg::COUNT_W'(0));
    queue_demod(16'sh0000, 16'sh0000);
    queue_demod(16'sh1234, -16'sh4321);

    // Random phases, each with its own point count.
    n_words = 0;
    phase   = 0;
    while (n_words < RAND_WORDS) begin
      case (phase)
        0:       n_cfg = 1;
        1:       n_cfg = 256;
        2:       n_cfg = 0;
        3:       n_cfg = 511;
        4:       n_cfg = 2;
        5:       n_cfg = 257;
        default: begin
          t = $urandom_range(99);
          if (t < 70) n_cfg = $urandom_range(1, 24);
          else if (t < 85) n_cfg = $urandom_range(25, 256);
          else n_cfg = $urandom_range(0, 511);
        end
      endcase
      phase++;
      write_count(n_cfg[apsk_pkg::COUNT_W-1:0]);
      span = (n_cfg == 0) ? 1 : (n_cfg > NPTS) ? NPTS : n_cfg;
      for (int unsigned e = 0; e < span; e++) begin
        if (!g_loaded[e]) begin
          queue_load(e, pick_coord(), pick_coord(), 8'($urandom));
          n_words++;
        end
      end
      burst = (span > 64) ? 8 : 30;
      for (int unsigned b = 0; b < burst; b++) begin
        t = $urandom_range(99);
        if (t < 12) begin
          queue_load($urandom_range(0, NPTS - 1), pick_coord(), pick_coord(),
                     8'($urandom));
        end else if (t < 27) begin
          si = 16'($urandom);
          sq = ($urandom_range(3) == 0) ? 16'sh0000 : 16'($urandom);
          queue_demod(si, sq);
        end else begin
          // A sample close to one loaded point in the scanned range.
          k = $urandom_range(0, span - 1);
          t = int'(g_i[k]) + int'($urandom_range(0, 1023)) - 512;
          si = t[15:0];
          t = int'(g_q[k]) + int'($urandom_range(0, 1023)) - 512;
          sq = t[15:0];
          queue_demod(si, sq);
        end
        n_words++;
      end
    end

    wait_drained();
    if (pending_labels.size() != 0) begin
      $error("%0d expected labels never arrived", pending_labels.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
